// File: hdl/sscop_pkg.sv
package sscop_pkg;

    localparam int COLORS = 3;
    localparam int PAIRS  = COLORS * COLORS;
    localparam int SUM_W  = 39;
    localparam int SAT_W  = 64;

    typedef logic [1:0] t_color;

    typedef struct packed {
        logic acc_en;
        logic dump;
        logic shift;
    } t_cell_ctl;

    function automatic logic signed [SAT_W-1:0] sat_add(
        input logic signed [SAT_W-1:0] a,
        input logic signed [SAT_W-1:0] b
    );
        logic signed [SAT_W:0] s;
        s = {a[SAT_W-1], a} + {b[SAT_W-1], b};
        if (s[SAT_W] != s[SAT_W-1]) begin
            return s[SAT_W] ? {1'b1, {(SAT_W-1){1'b0}}} : {1'b0, {(SAT_W-1){1'b1}}};
        end
        return s[SAT_W-1:0];
    endfunction

endpackage

// File: hdl/sscop_cell.sv
module sscop_cell #(
    parameter int DW  = 18,
    parameter int AW  = 40,
    parameter bit SAT = 1'b0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sscop_pkg::t_cell_ctl                i_ctl,
    input  logic signed [DW-1:0]                i_ar,
    input  logic signed [DW-1:0]                i_ai,
    input  logic signed [DW-1:0]                i_br,
    input  logic signed [DW-1:0]                i_bi,
    input  logic signed [sscop_pkg::SUM_W-1:0]  i_nxt_re,
    input  logic signed [sscop_pkg::SUM_W-1:0]  i_nxt_im,
    input  logic                                i_nxt_vld,
    output logic signed [sscop_pkg::SUM_W-1:0]  o_re,
    output logic signed [sscop_pkg::SUM_W-1:0]  o_im,
    output logic                                o_vld
);
    import sscop_pkg::*;

    localparam int PW = 2 * DW;

    logic signed [PW-1:0]    r_prr, r_pii, r_pir, r_pri;
    logic signed [AW-1:0]    r_acc_re, r_acc_im, n_acc_re, n_acc_im;
    logic signed [AW-1:0]    w_base_re, w_base_im;
    logic signed [SUM_W-1:0] w_sat_re, w_sat_im, r_hold_re, r_hold_im;
    logic                    r_vld;

    always_ff @(posedge i_clk) begin
        r_prr <= i_ar * i_br;
        r_pii <= i_ai * i_bi;
        r_pir <= i_ai * i_br;
        r_pri <= i_ar * i_bi;
    end

    assign w_base_re = i_ctl.dump ? '0 : r_acc_re;
    assign w_base_im = i_ctl.dump ? '0 : r_acc_im;

    generate
        if (SAT) begin : g_sat
            always_comb begin
                n_acc_re = w_base_re;
                n_acc_im = w_base_im;
                if (i_ctl.acc_en) begin
                    n_acc_re = sat_add(sat_add(w_base_re, SAT_W'(r_prr)), SAT_W'(r_pii));
                    n_acc_im = sat_add(sat_add(w_base_im, SAT_W'(r_pir)), -SAT_W'(r_pri));
                end
            end
        end else begin : g_exact
            always_comb begin
                n_acc_re = w_base_re;
                n_acc_im = w_base_im;
                if (i_ctl.acc_en) begin
                    n_acc_re = w_base_re + AW'(r_prr) + AW'(r_pii);
                    n_acc_im = w_base_im + AW'(r_pir) - AW'(r_pri);
                end
            end
        end

        if (AW > SUM_W) begin : g_clamp
            logic [AW-SUM_W:0] w_hi_re, w_hi_im;
            assign w_hi_re = r_acc_re[AW-1:SUM_W-1];
            assign w_hi_im = r_acc_im[AW-1:SUM_W-1];
            always_comb begin
                w_sat_re = r_acc_re[SUM_W-1:0];
                w_sat_im = r_acc_im[SUM_W-1:0];
                if (!((&w_hi_re) || !(|w_hi_re))) begin
                    w_sat_re = w_hi_re[AW-SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                 : {1'b0, {(SUM_W-1){1'b1}}};
                end
                if (!((&w_hi_im) || !(|w_hi_im))) begin
                    w_sat_im = w_hi_im[AW-SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                 : {1'b0, {(SUM_W-1){1'b1}}};
                end
            end
        end else begin : g_ext
            assign w_sat_re = SUM_W'(r_acc_re);
            assign w_sat_im = SUM_W'(r_acc_im);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
            r_vld    <= 1'b0;
        end else begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
            if (i_ctl.dump) begin
                r_vld <= 1'b1;
            end else if (i_ctl.shift) begin
                r_vld <= i_nxt_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.dump) begin
            r_hold_re <= w_sat_re;
            r_hold_im <= w_sat_im;
        end else if (i_ctl.shift) begin
            r_hold_re <= i_nxt_re;
            r_hold_im <= i_nxt_im;
        end
    end

    assign o_re  = r_hold_re;
    assign o_im  = r_hold_im;
    assign o_vld = r_vld;

endmodule

// File: hdl/spin_summed_color_outer_product_unit.sv
// Spin-summed color outer product.
// Input channel (i_in_valid / o_in_ready): one word per spin component, with
// three complex color entries of A and of B. Every input word adds
// A[i]*conj(B[j]) into nine accumulator cells, one cell per color pair.
// After SPINS words the nine sums go out on the result channel
// (o_out_valid / i_out_ready), row-major, o_last on row 2, col 2.
// Output: the last spin word passes the input registers, the product register,
// the accumulate and the load of the output chain before the first result word
// is valid, then one word per cycle while the receiver takes them.
// Throughput: one input word per cycle inside a group; the last spin word of
// a group is held off until the nine-stage output chain of the previous group
// has drained, so words of the next group other than its last are taken while
// the sums of the previous group go out.
// A stalled receiver freezes the output chain; accumulation of the next
// group goes on until its last spin word.
// Reset clears accumulators, spin count and the valid flags of the output chain.
module spin_summed_color_outer_product_unit #(
    parameter int SPINS      = 4,
    parameter int DATA_WIDTH = 18
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [DATA_WIDTH-1:0]        i_a0_re,
    input  logic signed [DATA_WIDTH-1:0]        i_a0_im,
    input  logic signed [DATA_WIDTH-1:0]        i_a1_re,
    input  logic signed [DATA_WIDTH-1:0]        i_a1_im,
    input  logic signed [DATA_WIDTH-1:0]        i_a2_re,
    input  logic signed [DATA_WIDTH-1:0]        i_a2_im,
    input  logic signed [DATA_WIDTH-1:0]        i_b0_re,
    input  logic signed [DATA_WIDTH-1:0]        i_b0_im,
    input  logic signed [DATA_WIDTH-1:0]        i_b1_re,
    input  logic signed [DATA_WIDTH-1:0]        i_b1_im,
    input  logic signed [DATA_WIDTH-1:0]        i_b2_re,
    input  logic signed [DATA_WIDTH-1:0]        i_b2_im,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sscop_pkg::t_color                   o_row,
    output sscop_pkg::t_color                   o_col,
    output logic signed [sscop_pkg::SUM_W-1:0]  o_sum_re,
    output logic signed [sscop_pkg::SUM_W-1:0]  o_sum_im,
    output logic                                o_last
);
    import sscop_pkg::*;

    localparam int CNT_W     = (SPINS > 1) ? $clog2(SPINS) : 1;
    localparam int ACC_EXACT = 2 * DATA_WIDTH + $clog2(2 * SPINS) + 1;
    localparam bit ACC_SAT   = (ACC_EXACT > SAT_W);
    localparam int ACC_W     = ACC_SAT ? SAT_W : ACC_EXACT;

    logic [CNT_W-1:0]             r_cnt;
    logic                         r_v0, r_l0, r_v1, r_l1, r_dump;
    logic                         w_in_last, w_in_acc, w_out_acc, w_busy;
    logic signed [DATA_WIDTH-1:0] r_ar [COLORS];
    logic signed [DATA_WIDTH-1:0] r_ai [COLORS];
    logic signed [DATA_WIDTH-1:0] r_br [COLORS];
    logic signed [DATA_WIDTH-1:0] r_bi [COLORS];
    t_color                       r_row, r_col;
    t_cell_ctl                    w_ctl;

    logic signed [SUM_W-1:0]      w_re  [PAIRS+1];
    logic signed [SUM_W-1:0]      w_im  [PAIRS+1];
    logic                         w_vld [PAIRS+1];

    assign w_in_last  = (r_cnt == CNT_W'(SPINS - 1));
    assign w_busy     = w_vld[0] || (r_v0 && r_l0) || (r_v1 && r_l1) || r_dump;
    assign o_in_ready = !(w_in_last && w_busy);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_acc  = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_v0   <= 1'b0;
            r_l0   <= 1'b0;
            r_v1   <= 1'b0;
            r_l1   <= 1'b0;
            r_dump <= 1'b0;
            r_row  <= '0;
            r_col  <= '0;
        end else begin
            r_v0   <= w_in_acc;
            r_l0   <= w_in_last;
            r_v1   <= r_v0;
            r_l1   <= r_l0;
            r_dump <= r_v1 && r_l1;
            if (w_in_acc) begin
                r_cnt <= w_in_last ? '0 : r_cnt + 1'b1;
            end
            if (w_out_acc) begin
                if (r_col == t_color'(COLORS - 1)) begin
                    r_col <= '0;
                    r_row <= (r_row == t_color'(COLORS - 1)) ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ar[0] <= i_a0_re;
            r_ai[0] <= i_a0_im;
            r_ar[1] <= i_a1_re;
            r_ai[1] <= i_a1_im;
            r_ar[2] <= i_a2_re;
            r_ai[2] <= i_a2_im;
            r_br[0] <= i_b0_re;
            r_bi[0] <= i_b0_im;
            r_br[1] <= i_b1_re;
            r_bi[1] <= i_b1_im;
            r_br[2] <= i_b2_re;
            r_bi[2] <= i_b2_im;
        end
    end

    assign w_ctl.acc_en = r_v1;
    assign w_ctl.dump   = r_dump;
    assign w_ctl.shift  = w_out_acc;

    assign w_re[PAIRS]  = '0;
    assign w_im[PAIRS]  = '0;
    assign w_vld[PAIRS] = 1'b0;

    generate
        for (genvar k = 0; k < PAIRS; k++) begin : g_cell
            sscop_cell #(
                .DW  (DATA_WIDTH),
                .AW  (ACC_W),
                .SAT (ACC_SAT)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_ar      (r_ar[k / COLORS]),
                .i_ai      (r_ai[k / COLORS]),
                .i_br      (r_br[k % COLORS]),
                .i_bi      (r_bi[k % COLORS]),
                .i_nxt_re  (w_re[k+1]),
                .i_nxt_im  (w_im[k+1]),
                .i_nxt_vld (w_vld[k+1]),
                .o_re      (w_re[k]),
                .o_im      (w_im[k]),
                .o_vld     (w_vld[k])
            );
        end
    endgenerate

    assign o_out_valid = w_vld[0];
    assign o_sum_re    = w_re[0];
    assign o_sum_im    = w_im[0];
    assign o_row       = r_row;
    assign o_col       = r_col;
    assign o_last      = (r_row == t_color'(COLORS - 1)) && (r_col == t_color'(COLORS - 1));

    // chain must be empty when a group lands in it
    a_dump_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dump |-> !w_vld[0])
        else $error("group dumped into a busy output chain");

    a_one_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_v0 && r_l0, r_v1 && r_l1, r_dump}) <= 1)
        else $error("two group ends in flight");

    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dump |=> o_out_valid && (r_row == '0) && (r_col == '0))
        else $error("group does not start at row 0, col 0");

    a_last_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last) |=> !o_out_valid)
        else $error("word left in chain after last");

endmodule
